// File: src/hcr_pkg.sv
// shared types, constants and helper functions for the character reference decoder
// no dependencies; imported by hcr_decode and html_char_reference_decoder
`default_nettype none

package hcr_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_AMP,
    MODE_HASH,
    MODE_DEC,
    MODE_HEX,
    MODE_NAME,
    MODE_DONE
  } mode_t;

  localparam int NUM_NAMES = 12;
  localparam int MAX_OUT   = 6;

  localparam logic [NUM_NAMES-1:0] ALL_NAMES = '1;
  localparam logic [16:0] CODE_SAT = 17'h10000;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  localparam logic [7:0] NAME_TEXT [NUM_NAMES][5] = '{
    '{"a", "m", "p", 8'h00, 8'h00},
    '{"l", "t", 8'h00, 8'h00, 8'h00},
    '{"g", "t", 8'h00, 8'h00, 8'h00},
    '{"q", "u", "o", "t", 8'h00},
    '{"a", "p", "o", "s", 8'h00},
    '{"n", "b", "s", "p", 8'h00},
    '{"c", "o", "p", "y", 8'h00},
    '{"r", "e", "g", 8'h00, 8'h00},
    '{"m", "d", "a", "s", "h"},
    '{"n", "d", "a", "s", "h"},
    '{"l", "a", "q", "u", "o"},
    '{"r", "a", "q", "u", "o"}
  };

  localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [7:0] VALUE_TEXT [NUM_NAMES][3] = '{
    '{8'h26, 8'h00, 8'h00},
    '{8'h3C, 8'h00, 8'h00},
    '{8'h3E, 8'h00, 8'h00},
    '{8'h22, 8'h00, 8'h00},
    '{8'h27, 8'h00, 8'h00},
    '{8'h20, 8'h00, 8'h00},
    '{8'hC2, 8'hA9, 8'h00},
    '{8'hC2, 8'hAE, 8'h00},
    '{8'hE2, 8'h80, 8'h94},
    '{8'hE2, 8'h80, 8'h93},
    '{8'hC2, 8'hAB, 8'h00},
    '{8'hC2, 8'hBB, 8'h00}
  };

  localparam logic [1:0] VALUE_LEN [NUM_NAMES] = '{
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd2, 2'd2
  };

  // short byte run, up to five used
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] byt;
    logic [2:0]              len;
  } seg_t;

  // all bytes caused by one item
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] byt;
    logic [2:0]              cnt;
  } burst_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t digit_of(logic [7:0] c, logic hex);
    digit_t d;
    d = '0;
    if (c inside {[8'h30:8'h39]}) begin
      d.ok  = 1'b1;
      d.val = c[3:0];
    end else if (hex && (c inside {[8'h61:8'h66], [8'h41:8'h46]})) begin
      d.ok  = 1'b1;
      d.val = c[3:0] + 4'd9;
    end
    return d;
  endfunction

  function automatic seg_t code_seg(logic [16:0] cp);
    seg_t s;
    s = '0;
    if (cp < 17'h80) begin
      s.byt[0] = cp[7:0];
      s.len    = 3'd1;
    end else if (cp < 17'h800) begin
      s.byt[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
      s.byt[1] = UTF8_CONT | {2'b00, cp[5:0]};
      s.len    = 3'd2;
    end else if (cp < CODE_SAT) begin
      s.byt[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
      s.byt[1] = UTF8_CONT | {2'b00, cp[11:6]};
      s.byt[2] = UTF8_CONT | {2'b00, cp[5:0]};
      s.len    = 3'd3;
    end else begin
      s.byt[0] = CH_QMARK;
      s.len    = 3'd1;
    end
    return s;
  endfunction

  function automatic seg_t value_seg(logic [3:0] idx);
    seg_t s;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      s.byt[k] = VALUE_TEXT[idx][k];
    end
    s.len = {1'b0, VALUE_LEN[idx]};
    return s;
  endfunction

  function automatic seg_t unmatched_seg(logic [3:0][7:0] pref, logic [2:0] cnt);
    seg_t s;
    s = '0;
    s.byt[0]   = CH_AMP;
    s.byt[4:1] = pref;
    s.len      = cnt + 3'd1;
    return s;
  endfunction

  function automatic burst_t merge_segs(seg_t a, logic b_ok, logic [7:0] b, seg_t c);
    burst_t     r;
    logic [3:0] la;
    logic [3:0] lab;
    logic [3:0] tot;
    logic [3:0] j;
    la  = {1'b0, a.len};
    lab = la + {3'b000, b_ok};
    tot = lab + {1'b0, c.len};
    r   = '0;
    for (int i = 0; i < MAX_OUT; i++) begin
      j = 4'(i) - lab;
      if (4'(i) < la) begin
        r.byt[i] = a.byt[i];
      end else if (4'(i) < lab) begin
        r.byt[i] = b;
      end else if (j < 4'(MAX_OUT)) begin
        r.byt[i] = c.byt[j[2:0]];
      end
    end
    r.cnt = (tot > 4'(MAX_OUT)) ? 3'(MAX_OUT) : tot[2:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/hcr_decode.sv
// reference scanner: scan state registers and the one-pass decode of an item
// depends on hcr_pkg
`default_nettype none

module hcr_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_last,
  output hcr_pkg::burst_t      burst
);
  import hcr_pkg::*;

  mode_t                 mode;
  mode_t                 mode_next;
  logic [16:0]           acc;
  logic [16:0]           acc_next;
  logic [3:0][7:0]       pref;
  logic [3:0][7:0]       pref_next;
  logic [2:0]            pcnt;
  logic [2:0]            pcnt_next;
  logic [NUM_NAMES-1:0]  cand;
  logic [NUM_NAMES-1:0]  cand_next;
  logic [3:0]            matched;
  logic [3:0]            matched_next;

  logic [2:0]            k;
  logic [NUM_NAMES-1:0]  cset;
  logic [NUM_NAMES-1:0]  hits;
  logic [NUM_NAMES-1:0]  fulls;
  logic [3:0]            full_idx;
  digit_t                dig;
  logic [20:0]           acc_mul;
  logic [20:0]           acc_sum;
  logic                  num_step;
  logic                  close;
  logic                  redo;
  logic                  pass;
  seg_t                  seg_a;
  seg_t                  seg_c;

  always_comb begin
    mode_next    = mode;
    acc_next     = acc;
    pref_next    = pref;
    pcnt_next    = pcnt;
    cand_next    = cand;
    matched_next = matched;
    seg_a        = '0;
    seg_c        = '0;
    num_step     = 1'b0;
    close        = 1'b0;
    redo         = 1'b0;
    pass         = 1'b0;

    // name match against the live candidates
    k        = (mode == MODE_AMP) ? 3'd0 : pcnt;
    cset     = (mode == MODE_AMP) ? ALL_NAMES : cand;
    hits     = '0;
    fulls    = '0;
    full_idx = '0;
    for (int i = 0; i < NUM_NAMES; i++) begin
      if (cset[i] && (NAME_LEN[i] > k) && (NAME_TEXT[i][k] == in_byte)) begin
        hits[i] = 1'b1;
        if (NAME_LEN[i] == k + 3'd1) begin
          fulls[i] = 1'b1;
        end
      end
    end
    for (int i = NUM_NAMES - 1; i >= 0; i--) begin
      if (fulls[i]) begin
        full_idx = 4'(i);
      end
    end

    // numeric accumulate with saturation
    dig     = digit_of(in_byte, mode == MODE_HEX);
    acc_mul = (mode == MODE_HEX) ? {acc, 4'b0000}
                                 : ({1'b0, acc, 3'b000} + {3'b000, acc, 1'b0});
    acc_sum = acc_mul + {17'd0, dig.val};

    case (mode)
      MODE_AMP, MODE_NAME: begin
        if ((mode == MODE_AMP) && (in_byte == CH_HASH)) begin
          mode_next = MODE_HASH;
          acc_next  = '0;
        end else if (|fulls) begin
          matched_next = full_idx;
          mode_next    = MODE_DONE;
          pcnt_next    = k;
          cand_next    = cset;
        end else if ((|hits) && (k < 3'd4)) begin
          pref_next[k[1:0]] = in_byte;
          pcnt_next         = k + 3'd1;
          cand_next         = hits;
          mode_next         = MODE_NAME;
        end else begin
          seg_a = unmatched_seg(pref, k);
          close = 1'b1;
          redo  = 1'b1;
        end
      end
      MODE_HASH: begin
        if ((in_byte == CH_LOW_X) || (in_byte == CH_UP_X)) begin
          mode_next = MODE_HEX;
        end else begin
          mode_next = MODE_DEC;
          num_step  = 1'b1;
        end
      end
      MODE_DEC, MODE_HEX: begin
        num_step = 1'b1;
      end
      MODE_DONE: begin
        seg_a = value_seg(matched);
        close = 1'b1;
        redo  = (in_byte != CH_SEMI);
      end
      default: begin
        close = 1'b1;
        redo  = 1'b1;
      end
    endcase

    if (num_step) begin
      if (dig.ok) begin
        acc_next = (acc_sum > {4'd0, CODE_SAT}) ? CODE_SAT : acc_sum[16:0];
      end else begin
        seg_a = code_seg(acc);
        close = 1'b1;
        redo  = (in_byte != CH_SEMI);
      end
    end

    if (close) begin
      mode_next = MODE_IDLE;
      acc_next  = '0;
      pcnt_next = '0;
      cand_next = ALL_NAMES;
    end

    // byte handled afresh in text mode
    if (redo) begin
      if (in_byte == CH_AMP) begin
        mode_next = MODE_AMP;
      end else begin
        pass = 1'b1;
      end
    end

    // end of stream flush
    if (in_last) begin
      case (mode_next)
        MODE_AMP, MODE_NAME:           seg_c = unmatched_seg(pref_next, pcnt_next);
        MODE_HASH, MODE_DEC, MODE_HEX: seg_c = code_seg(acc_next);
        MODE_DONE:                     seg_c = value_seg(matched_next);
        default:                       seg_c = '0;
      endcase
      mode_next = MODE_IDLE;
      acc_next  = '0;
      pcnt_next = '0;
      cand_next = ALL_NAMES;
    end

    burst = merge_segs(seg_a, pass, in_byte, seg_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      acc     <= '0;
      pcnt    <= '0;
      cand    <= ALL_NAMES;
      matched <= '0;
    end else if (take) begin
      mode    <= mode_next;
      acc     <= acc_next;
      pcnt    <= pcnt_next;
      cand    <= cand_next;
      matched <= matched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pref <= pref_next;
    end
  end

endmodule

`default_nettype wire

// File: src/html_char_reference_decoder.sv
// top level of the character reference decoder: stream ports and output byte buffer
// depends on hcr_pkg and hcr_decode
//
// usage:
//   input stream s_*: one text byte per item, s_tlast marks the final byte of a stream
//   and flushes any reference still open. output stream m_*: decoded bytes, m_tlast
//   set on the last byte caused by one input item.
//   an item is decoded in the cycle it is accepted; its bytes (zero to six) sit in the
//   output buffer from the next cycle. throughput: one item per cycle while each item
//   gives at most one byte and the receiver takes every byte; an item giving more bytes
//   holds the output buffer until they drain, and the next item is taken in the cycle its
//   last byte is taken. items giving no byte never stall the input.
//   when the receiver stalls, the buffer holds and s_tready drops once it is not
//   draining its final byte.
//   reset clears the scan state to plain text mode and empties the output buffer;
//   the block takes items in the first cycle after reset.
`default_nettype none

module html_char_reference_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tlast,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast
);
  import hcr_pkg::*;

  burst_t                  burst;
  logic                    take;
  logic                    give;
  logic [MAX_OUT-1:0][7:0] obuf;
  logic [2:0]              rem;

  assign s_tready = !rst && ((rem == 3'd0) || ((rem == 3'd1) && m_tready));
  assign take     = s_tvalid && s_tready;
  assign give     = m_tvalid && m_tready;

  hcr_decode u_dec (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (s_tdata),
    .in_last (s_tlast),
    .burst   (burst)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (take) begin
      rem <= burst.cnt;
    end else if (give) begin
      rem <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      obuf <= burst.byt;
    end else if (give) begin
      obuf <= {8'h00, obuf[MAX_OUT-1:1]};
    end
  end

  assign m_tvalid = (rem != 3'd0);
  assign m_tdata  = obuf[0];
  assign m_tlast  = (rem == 3'd1);

endmodule

`default_nettype wire

// File: src/hcr_checker.sv
// port-level checks for the character reference decoder, bound to the top level
// depends on html_char_reference_decoder port names
`default_nettype none

module hcr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // output buffer empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // stalled output holds its byte
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // input taken only when the buffer is empty or draining its final byte
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid || (m_tlast && m_tready))
    else $error("input ready while output bytes pending");

  // a burst continues without gaps
  a_burst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("burst broken before last byte");

  // no output without an accepted item
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
    else $error("output appeared without input");

endmodule

bind html_char_reference_decoder hcr_checker u_chk (.*);

`default_nettype wire
